// ===== design/ksl_pkg.sv =====
`default_nettype none

package ksl_pkg;

  // Field widths of one word on each channel
  localparam int unsigned OpW    = 3;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned GradeW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 7;

  // Operation codes; codes above OP_QUERY behave as a query
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

  // One stored list entry
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [GradeW-1:0] grade;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/ksl_in_if.sv =====
`default_nettype none

interface ksl_in_if;
  logic                              valid;
  logic                              ready;
  logic [ksl_pkg::OpW-1:0]           operation;
  logic signed [ksl_pkg::KeyW-1:0]   entry_key;
  logic [ksl_pkg::GradeW-1:0]        entry_grade;

  modport source (output valid, operation, entry_key, entry_grade, input ready);
  modport sink   (input valid, operation, entry_key, entry_grade, output ready);
endinterface

`default_nettype wire

// ===== design/ksl_out_if.sv =====
`default_nettype none

interface ksl_out_if;
  logic                         valid;
  logic                         ready;
  ksl_pkg::status_e             status;
  logic [ksl_pkg::GradeW-1:0]   found_grade;
  logic [ksl_pkg::CountW-1:0]   entry_count;
  logic                         is_empty;

  modport source (output valid, status, found_grade, entry_count, is_empty, input ready);
  modport sink   (input valid, status, found_grade, entry_count, is_empty, output ready);
endinterface

`default_nettype wire

// ===== design/keyed_sequential_list_core.sv =====
// Keyed list of up to CAPACITY key/grade entries held in insertion order in a
// single-port-read, single-port-write memory. Insert, clear and query finish in
// the cycle they are accepted and show their result word on the next cycle.
// Search and delete walk the memory one entry per cycle through the registered
// read port: a search stops at the first matching entry (at the end of the list
// when nothing matches, with no read at all on an empty list), and a delete goes
// on to the end of the list, since the same read port then moves every later
// entry down one place. Input is taken only while the sequencer is idle; a
// finished result waits in an output register and the next word may be
// accepted in the cycle that result is taken. Stored entries are never
// cleared: only entries below the fill count are ever read.
`default_nettype none

module keyed_sequential_list_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ksl_in_if.sink       in_i,
  ksl_out_if.source    out_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  ksl_pkg::state_e  state_q, state_d;
  ksl_pkg::op_e     op_q, op_d;
  logic [ksl_pkg::KeyW-1:0]   key_q, key_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  ksl_pkg::status_e status_q, status_d;
  logic [ksl_pkg::GradeW-1:0] found_q, found_d;

  ksl_pkg::entry_t  mem_q [CAPACITY];
  ksl_pkg::entry_t  rdata_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ksl_pkg::entry_t  wr_data;

  logic             in_ready;
  logic             accept;
  ksl_pkg::op_e     in_op;
  logic             more;
  logic             hit;
  logic             scan_end;
  logic [CW-1:0]    shift_dst;

  // Handshake and scan conditions
  assign in_ready  = (state_q == ksl_pkg::S_IDLE) && (!out_valid_q || out_o.ready);
  assign accept    = in_i.valid && in_ready;
  assign in_op     = ksl_pkg::op_e'(in_i.operation);
  assign more      = ptr_q < count_q;
  assign hit       = pend_q && (rdata_q.key == key_q);
  assign scan_end  = !pend_q && !more;
  assign shift_dst = ptr_q - CW'(2);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ksl_pkg::S_IDLE: begin
        if (accept && (in_op == ksl_pkg::OP_DELETE || in_op == ksl_pkg::OP_SEARCH)) begin
          state_d = ksl_pkg::S_SCAN;
        end
      end
      ksl_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (op_q == ksl_pkg::OP_DELETE) ? ksl_pkg::S_SHIFT : ksl_pkg::S_IDLE;
        end else if (scan_end) begin
          state_d = ksl_pkg::S_IDLE;
        end
      end
      ksl_pkg::S_SHIFT: begin
        if (!pend_q) begin
          state_d = ksl_pkg::S_IDLE;
        end
      end
      default: state_d = ksl_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory control and result word
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];
    wr_data     = '{key: in_i.entry_key, grade: in_i.entry_grade};
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    found_d     = found_q;
    case (state_q)
      ksl_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = in_op;
          key_d = in_i.entry_key;
          ptr_d = '0;
          case (in_op)
            ksl_pkg::OP_INSERT: begin
              out_valid_d = 1'b1;
              found_d     = '0;
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ksl_pkg::ST_FULL;
              end else begin
                status_d = ksl_pkg::ST_OK;
                wr_en    = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            ksl_pkg::OP_DELETE, ksl_pkg::OP_SEARCH: begin
              // scan starts next cycle
            end
            ksl_pkg::OP_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              status_d    = ksl_pkg::ST_OK;
              found_d     = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              status_d    = ksl_pkg::ST_OK;
              found_d     = '0;
            end
          endcase
        end
      end
      ksl_pkg::S_SCAN: begin
        if (hit && op_q == ksl_pkg::OP_SEARCH) begin
          out_valid_d = 1'b1;
          status_d    = ksl_pkg::ST_OK;
          found_d     = rdata_q.grade;
        end else if (scan_end) begin
          out_valid_d = 1'b1;
          status_d    = ksl_pkg::ST_MISSING;
          found_d     = '0;
        end else begin
          // fetch the next entry; on a delete hit it is the first one to move
          rd_en  = more;
          pend_d = more;
          if (more) begin
            ptr_d = ptr_q + CW'(1);
          end
        end
      end
      ksl_pkg::S_SHIFT: begin
        if (pend_q) begin
          // move the fetched entry down one place and fetch the next
          wr_en   = 1'b1;
          wr_addr = shift_dst[AW-1:0];
          wr_data = rdata_q;
          rd_en   = more;
          pend_d  = more;
          if (more) begin
            ptr_d = ptr_q + CW'(1);
          end
        end else begin
          count_d     = count_q - CW'(1);
          out_valid_d = 1'b1;
          status_d    = ksl_pkg::ST_OK;
          found_d     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ksl_pkg::S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Ports
  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.found_grade = found_q;
  assign out_o.entry_count = ksl_pkg::CountW'(count_q);
  assign out_o.is_empty    = (count_q == '0);

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_full_only_at_capacity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ksl_pkg::ST_FULL) |-> (count_q == CW'(CAPACITY)))
    else $error("full reported below capacity");

  a_delete_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ksl_pkg::S_SHIFT && !pend_q) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("delete did not drop one entry");

  a_shift_from_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ksl_pkg::S_SCAN && hit && op_q == ksl_pkg::OP_DELETE)
      |=> (state_q == ksl_pkg::S_SHIFT && !out_valid_q))
    else $error("delete hit did not enter shift");

endmodule

`default_nettype wire
